// ----- rtl/core/fpa_pkg.sv -----
// Shared types, sizes, operation codes and saturation helper for the fixed-point ALU.
// No dependencies.
`default_nettype none
package fpa_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int unsigned WIDE_BITS = 2 * WORD_BITS + 2;

  localparam logic signed [WIDE_BITS-1:0] WORD_MAX =
    signed'((WIDE_BITS'(1) << (WORD_BITS - 1)) - WIDE_BITS'(1));
  localparam logic signed [WIDE_BITS-1:0] WORD_MIN = -WORD_MAX - WIDE_BITS'(1);

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
  } op_e;

  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic                   neg;
    logic                   dz;
    logic [WORD_BITS-1:0]   res;
    logic                   cmp;
    logic                   err;
    logic [WORD_BITS-1:0]   ma;
    logic [WORD_BITS-1:0]   den;
    logic [2*WORD_BITS-1:0] prod;
    logic [WORD_BITS-1:0]   rem;
    logic [NUM_BITS-1:0]    num;
    logic [NUM_BITS-1:0]    quo;
  } pipe_t;

  typedef struct packed {
    logic                 err;
    logic [WORD_BITS-1:0] res;
  } sat_t;

  function automatic sat_t fpa_sat(input logic signed [WIDE_BITS-1:0] v);
    sat_t s;
    s.err = (v > WORD_MAX) || (v < WORD_MIN);
    if (v > WORD_MAX) begin
      s.res = WORD_MAX[WORD_BITS-1:0];
    end else if (v < WORD_MIN) begin
      s.res = WORD_MIN[WORD_BITS-1:0];
    end else begin
      s.res = v[WORD_BITS-1:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fpa_div_stage.sv -----
// One restoring-division step: produces one quotient bit per stage.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire fpa_pkg::pipe_t pipe_i,
  output fpa_pkg::pipe_t      pipe_o
);

  fpa_pkg::pipe_t                   pipe_d, pipe_q;
  logic [fpa_pkg::WORD_BITS:0]      trial;
  logic                             fits;

  always_comb begin
    trial  = {pipe_i.rem, pipe_i.num[fpa_pkg::NUM_BITS-1]};
    fits   = trial >= {1'b0, pipe_i.den};
    pipe_d = pipe_i;
    pipe_d.num = {pipe_i.num[fpa_pkg::NUM_BITS-2:0], 1'b0};
    pipe_d.quo = {pipe_i.quo[fpa_pkg::NUM_BITS-2:0], fits};
    if (fits) begin
      pipe_d.rem = fpa_pkg::WORD_BITS'(trial - {1'b0, pipe_i.den});
    end else begin
      pipe_d.rem = trial[fpa_pkg::WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule
`default_nettype wire

// ----- rtl/core/fixed_point_alu.sv -----
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, compares, min/max, inc/dec, conversions.
// Fully pipelined: one request per cycle unless the output stalls. The 40 one-bit division
// stages set the depth; every operation takes the same path so results leave in order.
// A stall on the output freezes the whole pipeline. Depends on fpa_pkg, fpa_div_stage.
`default_nettype none
module fixed_point_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [3:0]  operation_i,
  input  wire logic signed [31:0] operand_a_i,
  input  wire logic signed [31:0] operand_b_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic signed [31:0] result_o,
  output logic             compare_true_o,
  output logic             error_o
);

  localparam int unsigned WB = fpa_pkg::WORD_BITS;
  localparam int unsigned WD = fpa_pkg::WIDE_BITS;
  localparam int unsigned NB = fpa_pkg::NUM_BITS;
  localparam int unsigned FB = fpa_pkg::FRAC_BITS;

  logic en;

  logic                 s0_valid_q;
  fpa_pkg::op_e         s0_op_q;
  logic signed [WB-1:0] s0_a_q, s0_b_q;

  fpa_pkg::pipe_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q, out_d, out_q;
  fpa_pkg::pipe_t chain [NB+1];

  logic signed [WD-1:0] wa, wb;
  fpa_pkg::sat_t        sat1, sat3, satq;
  logic [2*WB-1:0]      mrnd;
  logic [NB:0]          qrnd;

  assign en      = !(out_q.valid && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s0_op_q    <= fpa_pkg::OP_ADD;
      s0_a_q     <= '0;
      s0_b_q     <= '0;
    end else if (en) begin
      s0_valid_q <= valid_i;
      s0_op_q    <= fpa_pkg::op_e'(operation_i);
      s0_a_q     <= operand_a_i[WB-1:0];
      s0_b_q     <= operand_b_i[WB-1:0];
    end
  end

  always_comb begin
    wa   = WD'(s0_a_q);
    wb   = WD'(s0_b_q);
    s1_d = '0;
    s1_d.valid = s0_valid_q;
    s1_d.op    = s0_op_q;
    s1_d.neg   = s0_a_q[WB-1] ^ s0_b_q[WB-1];
    s1_d.dz    = s0_b_q == '0;
    s1_d.ma    = s0_a_q[WB-1] ? WB'(-wa) : s0_a_q[WB-1:0];
    s1_d.den   = s0_b_q[WB-1] ? WB'(-wb) : s0_b_q[WB-1:0];
    sat1       = fpa_pkg::fpa_sat('0);
    unique case (s0_op_q)
      fpa_pkg::OP_ADD:      sat1 = fpa_pkg::fpa_sat(wa + wb);
      fpa_pkg::OP_SUB:      sat1 = fpa_pkg::fpa_sat(wa - wb);
      fpa_pkg::OP_INC:      sat1 = fpa_pkg::fpa_sat(wa + WD'(1));
      fpa_pkg::OP_DEC:      sat1 = fpa_pkg::fpa_sat(wa - WD'(1));
      fpa_pkg::OP_FROM_INT: sat1 = fpa_pkg::fpa_sat(wa <<< FB);
      fpa_pkg::OP_TO_INT:   sat1 = fpa_pkg::fpa_sat(wa >>> FB);
      fpa_pkg::OP_MIN:      sat1 = fpa_pkg::fpa_sat((wa < wb) ? wa : wb);
      fpa_pkg::OP_MAX:      sat1 = fpa_pkg::fpa_sat((wa > wb) ? wa : wb);
      default:              sat1 = fpa_pkg::fpa_sat('0);
    endcase
    s1_d.res = sat1.res;
    s1_d.err = sat1.err;
    unique case (s0_op_q)
      fpa_pkg::OP_GT: s1_d.cmp = s0_a_q > s0_b_q;
      fpa_pkg::OP_LT: s1_d.cmp = s0_a_q < s0_b_q;
      fpa_pkg::OP_GE: s1_d.cmp = s0_a_q >= s0_b_q;
      fpa_pkg::OP_LE: s1_d.cmp = s0_a_q <= s0_b_q;
      fpa_pkg::OP_EQ: s1_d.cmp = s0_a_q == s0_b_q;
      fpa_pkg::OP_NE: s1_d.cmp = s0_a_q != s0_b_q;
      default:        s1_d.cmp = 1'b0;
    endcase
  end

  always_comb begin
    s2_d      = s1_q;
    s2_d.prod = s1_q.ma * s1_q.den;
  end

  always_comb begin
    s3_d = s2_q;
    mrnd = (s2_q.prod + ((2*WB)'(1) << (FB - 1))) >> FB;
    sat3 = fpa_pkg::fpa_sat(s2_q.neg ? -signed'(WD'(mrnd)) : signed'(WD'(mrnd)));
    if (s2_q.op == fpa_pkg::OP_MUL) begin
      s3_d.res = sat3.res;
      s3_d.err = sat3.err;
    end
    s3_d.rem = '0;
    s3_d.quo = '0;
    s3_d.num = {s2_q.ma, FB'(0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign chain[0] = s3_q;

  for (genvar k = 0; k < NB; k++) begin : g_div
    fpa_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .pipe_i (chain[k]),
      .pipe_o (chain[k+1])
    );
  end

  always_comb begin
    out_d = chain[NB];
    qrnd  = {1'b0, chain[NB].quo} +
            (NB+1)'({chain[NB].rem, 1'b0} >= {1'b0, chain[NB].den});
    satq  = fpa_pkg::fpa_sat(chain[NB].neg ? -signed'(WD'(qrnd)) : signed'(WD'(qrnd)));
    if (chain[NB].op == fpa_pkg::OP_DIV) begin
      if (chain[NB].dz) begin
        out_d.res = '0;
        out_d.err = 1'b1;
      end else begin
        out_d.res = satq.res;
        out_d.err = satq.err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en) begin
      out_q <= out_d;
    end
  end

  assign valid_o        = out_q.valid;
  assign result_o       = 32'(signed'(out_q.res));
  assign compare_true_o = out_q.cmp;
  assign error_o        = out_q.err;

endmodule
`default_nettype wire

// ----- rtl/core/fpa_checker.sv -----
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu.
`default_nettype none
module fpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [31:0] result_o,
  input wire logic        compare_true_o,
  input wire logic        error_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_o) && $stable(error_o))
    else $error("stalled result changed");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && compare_true_o |-> !error_o && result_o == 32'd0)
    else $error("compare result carries value or error");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("stall without pending result");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> stall_i)
    else $error("stall not caused by output side");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .stall_o        (stall_o),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .result_o       (result_o),
  .compare_true_o (compare_true_o),
  .error_o        (error_o)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU: directed corner requests per
// operation, then random requests with random idling on both sides. Depends on fpa_pkg.
`default_nettype none
module testbench;

  typedef struct packed {
    logic signed [31:0] res;
    logic               cmp;
    logic               err;
  } alu_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [3:0] operation_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic stall_o, valid_o, compare_true_o, error_o;
  logic signed [31:0] result_o;

  alu_out_t expected_q[$];
  int errors = 0;
  int longest_stall = 0;

  always #6 clk_i = ~clk_i;

  fixed_point_alu dut (.*);

  function automatic logic signed [63:0] saturate(input logic signed [63:0] v,
                                                  inout logic err);
    if (v > 64'sd2147483647) begin
      err = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      err = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic alu_out_t alu_predict(input fpa_pkg::op_e op,
                                           input logic signed [31:0] a32,
                                           input logic signed [31:0] b32);
    logic signed [63:0] a, b, r;
    logic [63:0] ma, mb, m;
    logic neg;
    alu_out_t o;
    a = a32;
    b = b32;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    r = 0;
    o = '0;
    case (op)
      fpa_pkg::OP_ADD: r = saturate(a + b, o.err);
      fpa_pkg::OP_SUB: r = saturate(a - b, o.err);
      fpa_pkg::OP_MUL: begin
        m = (ma * mb + 64'd128) >> 8;
        r = saturate(neg ? -$signed(m) : $signed(m), o.err);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          o.err = 1'b1;
        end else begin
          m = (2 * (ma << 8) + mb) / (2 * mb);
          r = saturate(neg ? -$signed(m) : $signed(m), o.err);
        end
      end
      fpa_pkg::OP_GT: o.cmp = a > b;
      fpa_pkg::OP_LT: o.cmp = a < b;
      fpa_pkg::OP_GE: o.cmp = a >= b;
      fpa_pkg::OP_LE: o.cmp = a <= b;
      fpa_pkg::OP_EQ: o.cmp = a == b;
      fpa_pkg::OP_NE: o.cmp = a != b;
      fpa_pkg::OP_MIN: r = a < b ? a : b;
      fpa_pkg::OP_MAX: r = a > b ? a : b;
      fpa_pkg::OP_INC: r = saturate(a + 1, o.err);
      fpa_pkg::OP_DEC: r = saturate(a - 1, o.err);
      fpa_pkg::OP_TO_INT: r = a >>> 8;
      default: r = saturate(a <<< 8, o.err);
    endcase
    o.res = r[31:0];
    return o;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_request(input fpa_pkg::op_e op, input logic [31:0] a,
                              input logic [31:0] b);
    int gap;
    valid_i <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (stall_o);
    expected_q.push_back(alu_predict(op, a, b));
    if ($urandom_range(0, 3) == 0) begin
      gap = gap_len();
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3) - 1;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      4: return $signed($urandom_range(0, 2047)) - 1024;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", result_o, 0);
      end else begin
        alu_out_t e;
        e = expected_q.pop_front();
        if (result_o !== e.res) report("result", result_o, e.res);
        if (compare_true_o !== e.cmp) report("compare_true", 32'(compare_true_o), 32'(e.cmp));
        if (error_o !== e.err) report("error", 32'(error_o), 32'(e.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if (longest_stall > 0) begin
      longest_stall--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_i <= 1'b1;
      longest_stall = gap_len();
    end else begin
      stall_i <= 1'b0;
    end
  end

  task automatic test_corners();
    logic [31:0] vals[8] = '{32'h7fffffff, 32'h80000000, 0, 1, 32'hffffffff,
                             32'h100, 32'hffffff00, 32'h80};
    for (int op = 0; op < 16; op++) begin
      send_request(fpa_pkg::op_e'(op), vals[op % 8], vals[(op + 3) % 8]);
    end
    send_request(fpa_pkg::OP_DIV, 32'h500, 0);
    send_request(fpa_pkg::OP_MUL, 32'h80, 32'h80);
    send_request(fpa_pkg::OP_MUL, 32'hffffff80, 32'h1);
    send_request(fpa_pkg::OP_DIV, 32'h1, 32'h2);
    send_request(fpa_pkg::OP_MIN, 32'h5, 32'h5);
    send_request(fpa_pkg::OP_MAX, 32'h80000000, 32'h7fffffff);
    send_request(fpa_pkg::OP_TO_INT, 32'hffffff01, 0);
    send_request(fpa_pkg::OP_FROM_INT, 32'hff800000, 0);
  endtask

  task automatic test_drain_pause();
    valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic test_random();
    for (int i = 0; i < 600; i++) begin
      send_request(fpa_pkg::op_e'($urandom_range(0, 15)), rand_operand(), rand_operand());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_drain_pause();
    test_random();
    valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/fpa_pkg.sv
rtl/core/fpa_div_stage.sv
rtl/core/fixed_point_alu.sv
rtl/core/fpa_checker.sv
sim/testbench.sv
